// ===== rtl/isa_pkg.sv =====
// Shared types and constants for the indexed shift array.
// No dependencies; imported by every module of the block.
`default_nettype none

package isa_pkg;

  // Default sizing
  localparam int CAPACITY_DEF      = 256;
  localparam int ELEMENT_WIDTH_DEF = 32;

  // Field widths fixed by the stream format
  localparam int POS_W     = 9;
  localparam int VALUE_W   = 32;
  localparam int COUNT_F_W = 9;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int TDATA_W   = 48;

  // Cells per readback group; each group is ORed into one register
  localparam int GROUP_SIZE = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_WRITE  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-item command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic rem;
    logic wr;
  } cell_op_t;

endpackage

`default_nettype wire

// ===== rtl/indexed_shift_array.sv =====
// Indexed shift array: ordered list with insert, remove, read and write at a position.
// Result path: the group readback register, then the output register; a stalled result
// side can hold a result between the two. Throughput: one item per cycle while the result
// side is not stalled; the cell chain moves the elements at and above the position on accept.
// Reset (rst_n low, synchronous) clears every cell and the count.
// Depends on isa_pkg and isa_cell.
`default_nettype none

module indexed_shift_array
  import isa_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,   // position[8:0], value[40:9], zero pad
  input  wire logic [KIND_W-1:0]  in_tuser,   // kind[1:0]
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,  // data_out[31:0], element_count[40:32],
                                              // is_empty[41], zero pad
  output logic [STATUS_W-1:0]     out_tuser   // status[1:0]
);

  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int EW         = ELEMENT_WIDTH;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  // ---------------- request decode ----------------
  logic                accept;
  kind_t               kind;
  logic [POS_W-1:0]    pos;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic signed [63:0]  val64;
  logic [EW-1:0]       val_ew;
  logic                is_ins;
  logic                range_err;
  logic                full_err;
  logic                req_ok;
  status_t             req_status;
  cell_op_t            op;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [CMP_W-1:0]    count_nxt_ext;

  assign accept  = in_tvalid && in_tready;
  assign kind    = kind_t'(in_tuser);
  assign pos     = in_tdata[POS_W-1:0];
  assign pos_ext = CMP_W'(pos);
  assign cnt_ext = CMP_W'(count_r);
  assign val64   = 64'(signed'(in_tdata[POS_W +: VALUE_W]));
  assign val_ew  = val64[EW-1:0];

  assign is_ins    = (kind == KIND_INSERT);
  assign range_err = is_ins ? (pos_ext > cnt_ext) : (pos_ext >= cnt_ext);
  assign full_err  = is_ins && !range_err && (count_r == FULL_CNT);
  assign req_ok    = !range_err && !full_err;

  always_comb begin
    priority if (range_err) req_status = ST_RANGE;
    else if (full_err)      req_status = ST_FULL;
    else                    req_status = ST_OK;
  end

  assign op.ins = accept && req_ok && is_ins;
  assign op.rem = accept && req_ok && (kind == KIND_REMOVE);
  assign op.wr  = accept && req_ok && (kind == KIND_WRITE);

  // ---------------- count ----------------
  always_comb begin
    count_nxt = count_r;
    if (op.ins)      count_nxt = count_r + CNT_W'(1);
    else if (op.rem) count_nxt = count_r - CNT_W'(1);
  end

  assign count_nxt_ext = CMP_W'(count_nxt);

  // ---------------- cell chain ----------------
  logic [EW-1:0] cell_data [CAPACITY];
  logic [EW-1:0] cell_hit  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [EW-1:0] lower_w;
    logic [EW-1:0] upper_w;

    if (i == 0) begin : g_first
      assign lower_w = '0;
    end else begin : g_mid_lo
      assign lower_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper_w = '0;
    end else begin : g_mid_hi
      assign upper_w = cell_data[i+1];
    end

    isa_cell #(
      .IDX   (i),
      .CMP_W (CMP_W),
      .EW    (EW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op_i    (op),
      .pos_i   (pos_ext),
      .val_i   (val_ew),
      .lower_i (lower_w),
      .upper_i (upper_w),
      .data_o  (cell_data[i]),
      .hit_o   (cell_hit[i])
    );
  end

  // ---------------- readback: group OR, then final OR ----------------
  logic [EW-1:0] grp_r   [NUM_GROUPS];
  logic [EW-1:0] grp_nxt [NUM_GROUPS];
  logic          sel_en;

  // Old value is returned for remove, read and write that pass the checks
  assign sel_en = req_ok && !is_ins;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | cell_hit[g * GROUP_SIZE + k];
        end
      end
      if (!sel_en) grp_nxt[g] = '0;
    end
  end

  logic                 pend_r;
  status_t              pend_status_r;
  logic [COUNT_F_W-1:0] pend_count_r;
  logic                 pend_empty_r;
  logic                 out_load;
  logic                 out_tvalid_r;

  assign out_load  = pend_r && (!out_tvalid_r || out_tready);
  assign in_tready = !pend_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept)        pend_r <= 1'b1;
      else if (out_load) pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      grp_r         <= grp_nxt;
      pend_status_r <= req_status;
      pend_count_r  <= count_nxt_ext[COUNT_F_W-1:0];
      pend_empty_r  <= (count_nxt == '0);
    end
  end

  logic [EW-1:0]      sel_w;
  logic signed [63:0] sel64;

  always_comb begin
    sel_w = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      sel_w = sel_w | grp_r[g];
    end
  end

  assign sel64 = 64'(signed'(sel_w));

  // ---------------- output register ----------------
  logic [VALUE_W-1:0]   out_data_r;
  status_t              out_status_r;
  logic [COUNT_F_W-1:0] out_count_r;
  logic                 out_empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load)        out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r   <= sel64[VALUE_W-1:0];
      out_status_r <= pend_status_r;
      out_count_r  <= pend_count_r;
      out_empty_r  <= pend_empty_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(TDATA_W - VALUE_W - COUNT_F_W - 1)'(0), out_empty_r,
                       out_count_r, out_data_r};

endmodule

`default_nettype wire

// ===== rtl/isa_cell.sv =====
// One storage cell of the shift chain: holds one element and moves it to a
// neighbor on insert or remove. Depends on isa_pkg.
`default_nettype none

module isa_cell
  import isa_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CMP_W = 9,
  parameter int EW    = ELEMENT_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_op_t         op_i,
  input  wire logic [CMP_W-1:0] pos_i,
  input  wire logic [EW-1:0]    val_i,
  input  wire logic [EW-1:0]    lower_i,  // element of cell IDX-1
  input  wire logic [EW-1:0]    upper_i,  // element of cell IDX+1
  output logic      [EW-1:0]    data_o,
  output logic      [EW-1:0]    hit_o     // element when position matches, else zero
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [EW-1:0] data_r;
  logic [EW-1:0] data_nxt;
  logic          at_pos;
  logic          above_pos;

  assign at_pos    = (pos_i == MY_IDX);
  assign above_pos = (MY_IDX > pos_i);

  // Cells above count hold zero, so the whole tail may shift freely.
  always_comb begin
    data_nxt = data_r;
    if (op_i.ins) begin
      if (at_pos)         data_nxt = val_i;
      else if (above_pos) data_nxt = lower_i;
    end else if (op_i.rem) begin
      if (at_pos || above_pos) data_nxt = upper_i;
    end else if (op_i.wr) begin
      if (at_pos) data_nxt = val_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data_o = data_r;
  assign hit_o  = at_pos ? data_r : '0;

endmodule

`default_nettype wire

// ===== rtl/isa_checker.sv =====
// Port-level checks for the indexed shift array, bound to the top level.
// Depends on isa_pkg and indexed_shift_array.
`default_nettype none

module isa_checker
  import isa_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tready,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [TDATA_W-1:0] out_tdata,
  input wire logic [STATUS_W-1:0] out_tuser
);

  // A rejected request never returns data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata[VALUE_W-1:0] == '0))
    else $error("error result carries nonzero data");

  // Empty flag agrees with the element count
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[VALUE_W + COUNT_F_W] ==
                    (out_tdata[VALUE_W +: COUNT_F_W] == '0)))
    else $error("is_empty disagrees with element_count");

  // Only the three defined status codes appear
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_RANGE ||
                    out_tuser == ST_FULL))
    else $error("undefined status code");

  // Input stalls only behind a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled with the result side free");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind indexed_shift_array isa_checker u_isa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== verif/tb_indexed_shift_array.sv =====
// Self-checking bench for indexed_shift_array: directed rows, then biased random requests.
// A shadow list predicts results of untyped rows; uses isa_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_indexed_shift_array;
  import isa_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 880;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;

  typedef struct {
    logic [31:0] data;
    status_t     status;
    logic [8:0]  count;
    logic        empty;
  } list_result_t;

  typedef struct {
    kind_t        kind;
    logic [8:0]   pos;
    logic [31:0]  value;
    bit           typed;
    list_result_t res;
  } list_req_t;

  typedef enum int {BIAS_MIX, BIAS_FILL, BIAS_DRAIN} bias_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [TDATA_W-1:0]  in_tdata;
  logic [KIND_W-1:0]   in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [TDATA_W-1:0]  out_tdata;
  logic [STATUS_W-1:0] out_tuser;

  // shadow copy of the list
  logic [31:0]  list_cells [CAP];
  int           list_count;

  list_result_t due_results [$];
  list_req_t    directed_rows [23];
  bit           cur_typed;
  list_result_t cur_expect;
  int           mismatches;
  int           quiet_cycles;
  bit           idle_on;
  bit           hold_req;
  int           rx_stall;

  indexed_shift_array uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic list_result_t list_update(kind_t kind, logic [8:0] pos, logic [31:0] value);
    list_result_t r;
    int p;
    r.data   = '0;
    r.status = ST_OK;
    p = int'(pos);
    if (kind == KIND_INSERT) begin
      // position is checked before fullness
      if (p > list_count) begin
        r.status = ST_RANGE;
      end else if (list_count >= CAP) begin
        r.status = ST_FULL;
      end else begin
        for (int i = list_count; i > p; i--) list_cells[i] = list_cells[i-1];
        list_cells[p] = value;
        list_count++;
      end
    end else if (p >= list_count) begin
      r.status = ST_RANGE;
    end else begin
      r.data = list_cells[p];
      if (kind == KIND_REMOVE) begin
        for (int i = p; i + 1 < list_count; i++) list_cells[i] = list_cells[i+1];
        list_cells[list_count-1] = '0;
        list_count--;
      end else if (kind == KIND_WRITE) begin
        list_cells[p] = value;
      end
    end
    r.count = list_count[8:0];
    r.empty = (list_count == 0);
    return r;
  endfunction

  function automatic list_req_t mk_row(kind_t kind, logic [8:0] pos, logic [31:0] value,
                                       bit typed, status_t status, logic [31:0] data,
                                       logic [8:0] count);
    list_req_t q;
    q.kind       = kind;
    q.pos        = pos;
    q.value      = value;
    q.typed      = typed;
    q.res.data   = data;
    q.res.status = status;
    q.res.count  = count;
    q.res.empty  = (count == 0);
    return q;
  endfunction

  function automatic list_req_t random_request(bias_t bias);
    list_req_t q;
    int roll;
    int top;
    roll = $urandom_range(0, 99);
    case (bias)
      BIAS_FILL:  q.kind = (roll < 80) ? KIND_INSERT : kind_t'($urandom_range(1, 3));
      BIAS_DRAIN: q.kind = (roll < 75) ? KIND_REMOVE : kind_t'($urandom_range(0, 3));
      default:    q.kind = kind_t'($urandom_range(0, 3));
    endcase
    // highest legal position for this kind; -1 when nothing is legal
    top  = (q.kind == KIND_INSERT) ? list_count : list_count - 1;
    roll = $urandom_range(0, 99);
    if (roll < 12 || top < 0) begin
      q.pos = 9'($urandom_range(0, 511));
    end else if (roll < 20) begin
      q.pos = '0;
    end else if (roll < 28) begin
      q.pos = 9'(top);
    end else begin
      q.pos = 9'($urandom_range(0, top));
    end
    case ($urandom_range(0, 11))
      0:       q.value = 32'h7fff_ffff;
      1:       q.value = 32'h8000_0000;
      2:       q.value = 32'h0000_0000;
      3:       q.value = 32'hffff_ffff;
      default: q.value = $urandom;
    endcase
    q.typed      = 1'b0;
    q.res.data   = '0;
    q.res.status = ST_OK;
    q.res.count  = '0;
    q.res.empty  = 1'b0;
    return q;
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic push_item(input list_req_t q);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    cur_typed  = q.typed;
    cur_expect = q.res;
    in_tvalid <= 1'b1;
    in_tuser  <= q.kind;
    in_tdata  <= {7'b0, q.value, q.pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // predictor and checker, sampled at the rising edge
  always @(posedge clk) begin : monitor
    list_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        want = list_update(kind_t'(in_tuser), in_tdata[8:0], in_tdata[40:9]);
        if (cur_typed) due_results.push_back(cur_expect);
        else           due_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("result with no pending request: tdata %0h status %0h", out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("data_out", want.data, out_tdata[31:0]);
          check_field("status", 32'(want.status), 32'(out_tuser));
          check_field("element_count", 32'(want.count), 32'(out_tdata[40:32]));
          check_field("is_empty", 32'(want.empty), 32'(out_tdata[41]));
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin : watchdog
    @(posedge rst_n);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    out_tready = 1'b0;
    rx_stall   = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_stall = HOLD_CYCLES;
      end else if (rx_stall == 0 && idle_on && $urandom_range(0, 9) == 0) begin
        rx_stall = $urandom_range(1, 15);
      end
      if (rx_stall > 0) begin
        out_tready <= 1'b0;
        rx_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    bias_t bias;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cur_typed    = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    list_count   = 0;
    foreach (list_cells[i]) list_cells[i] = '0;

    // empty-store errors, head/tail/middle forms, extreme values
    directed_rows[0]  = mk_row(KIND_READ,   9'd0,   32'h0,         1, ST_RANGE, 32'h0, 9'd0);
    directed_rows[1]  = mk_row(KIND_REMOVE, 9'd0,   32'h0,         1, ST_RANGE, 32'h0, 9'd0);
    directed_rows[2]  = mk_row(KIND_WRITE,  9'd0,   32'h5,         1, ST_RANGE, 32'h0, 9'd0);
    directed_rows[3]  = mk_row(KIND_INSERT, 9'd1,   32'h1,         1, ST_RANGE, 32'h0, 9'd0);
    directed_rows[4]  = mk_row(KIND_INSERT, 9'd511, 32'hffff_ffff, 1, ST_RANGE, 32'h0, 9'd0);
    directed_rows[5]  = mk_row(KIND_INSERT, 9'd0,   32'h7fff_ffff, 1, ST_OK,    32'h0, 9'd1);
    directed_rows[6]  = mk_row(KIND_INSERT, 9'd1,   32'h8000_0000, 1, ST_OK,    32'h0, 9'd2);
    directed_rows[7]  = mk_row(KIND_INSERT, 9'd0,   32'hffff_ffff, 1, ST_OK,    32'h0, 9'd3);
    directed_rows[8]  = mk_row(KIND_READ,   9'd0,   32'h0,         1, ST_OK, 32'hffff_ffff, 9'd3);
    directed_rows[9]  = mk_row(KIND_READ,   9'd2,   32'h0,         0, ST_OK,    32'h0, 9'd0);
    directed_rows[10] = mk_row(KIND_READ,   9'd3,   32'h0,         1, ST_RANGE, 32'h0, 9'd3);
    directed_rows[11] = mk_row(KIND_WRITE,  9'd1,   32'h0,         0, ST_OK,    32'h0, 9'd0);
    directed_rows[12] = mk_row(KIND_WRITE,  9'd1,   32'h5a5a_5a5a, 0, ST_OK,    32'h0, 9'd0);
    directed_rows[13] = mk_row(KIND_INSERT, 9'd1,   32'h1234_5678, 0, ST_OK,    32'h0, 9'd0);
    directed_rows[14] = mk_row(KIND_READ,   9'd1,   32'h0,         0, ST_OK,    32'h0, 9'd0);
    directed_rows[15] = mk_row(KIND_REMOVE, 9'd3,   32'h0,         0, ST_OK,    32'h0, 9'd0);
    directed_rows[16] = mk_row(KIND_REMOVE, 9'd511, 32'h0,         1, ST_RANGE, 32'h0, 9'd3);
    directed_rows[17] = mk_row(KIND_REMOVE, 9'd1,   32'h0,         0, ST_OK,    32'h0, 9'd0);
    directed_rows[18] = mk_row(KIND_REMOVE, 9'd0,   32'h0,         0, ST_OK,    32'h0, 9'd0);
    directed_rows[19] = mk_row(KIND_REMOVE, 9'd0,   32'h0,         0, ST_OK,    32'h0, 9'd0);
    directed_rows[20] = mk_row(KIND_READ,   9'd0,   32'h0,         1, ST_RANGE, 32'h0, 9'd0);
    directed_rows[21] = mk_row(KIND_WRITE,  9'd255, 32'hdead_beef, 1, ST_RANGE, 32'h0, 9'd0);
    directed_rows[22] = mk_row(KIND_INSERT, 9'd256, 32'h1,         1, ST_RANGE, 32'h0, 9'd0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) push_item(directed_rows[i]);

    // mix, then fill past full, then drain, then mix with no idling at the end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) hold_req = 1'b1;
      if (n == 760) idle_on = 1'b0;
      if (n < 200)      bias = BIAS_MIX;
      else if (n < 500) bias = BIAS_FILL;
      else if (n < 700) bias = BIAS_DRAIN;
      else              bias = BIAS_MIX;
      push_item(random_request(bias));
    end
    in_tvalid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
